// ===== design/ccv_pkg.sv =====
// Types and constants shared by the chunked container verifier.
`default_nettype none
package ccv_pkg;

  localparam logic [31:0] MagicXpkf = 32'h5850_4B46;
  localparam int unsigned QDepth = 4;

  typedef enum logic [2:0] {
    PH_HDR,
    PH_CHDR,
    PH_DATA,
    PH_PAD,
    PH_TAIL,
    PH_DRAIN
  } phase_e;

  typedef enum logic [1:0] {
    CFG_MAX_RAW    = 2'd0,
    CFG_MAX_PACKED = 2'd1,
    CFG_VERIFY     = 2'd2
  } cfg_idx_e;

  localparam logic [1:0] KindHeader = 2'd0;
  localparam logic [1:0] KindChunk  = 2'd1;
  localparam logic [1:0] KindEnd    = 2'd2;

  localparam logic [3:0] StOk        = 4'd0;
  localparam logic [3:0] StMagic     = 4'd1;
  localparam logic [3:0] StHdrSum    = 4'd2;
  localparam logic [3:0] StSize      = 4'd3;
  localparam logic [3:0] StPassword  = 4'd4;
  localparam logic [3:0] StChunkSum  = 4'd5;
  localparam logic [3:0] StDataSum   = 4'd6;
  localparam logic [3:0] StType      = 4'd7;
  localparam logic [3:0] StStored    = 4'd8;
  localparam logic [3:0] StTruncated = 4'd9;
  localparam logic [3:0] StRawTotal  = 4'd10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  status;
    logic [31:0] packer_type;
    logic [7:0]  chunk_kind;
    logic [31:0] chunk_offset;
    logic [31:0] chunk_packed_size;
    logic [31:0] chunk_raw_size;
    logic        last;
  } out_item_t;

endpackage
`default_nettype wire

// ===== design/chunked_container_verifier.sv =====
// Top level: streaming verifier for chunked packed-file containers.
// Results are registered into the result buffer when their byte is taken and are offered from it in order.
// Throughput: one byte per cycle; a byte gives at most two results, which queue in
// a four-entry result buffer, and input stalls while it cannot take two more.
// Reset: all file state returns to the file-header phase and the registers to
// their defaults; the block is ready for the first byte at once.
`default_nettype none
module chunked_container_verifier (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire ccv_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output ccv_pkg::out_item_t      out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);

  logic [31:0] max_raw_q, max_packed_q;
  logic        verify_q;

  ccv_pkg::phase_e phase_q, phase_d;
  logic [32:0] byte_offset_q, byte_offset_d;
  logic [31:0] field_shift_q, field_shift_d;
  logic [31:0] total_packed_q, total_packed_d;
  logic [31:0] total_raw_q, total_raw_d;
  logic [2:0]  header_flags_q, header_flags_d;
  logic [16:0] header_length_q, header_length_d;
  logic [7:0]  header_xor_q, header_xor_d;
  logic [15:0] lane_xor_q, lane_xor_d;
  logic [15:0] check_value_q, check_value_d;
  logic [7:0]  current_type_q, current_type_d;
  logic [31:0] current_packed_q, current_packed_d;
  logic [31:0] current_raw_q, current_raw_d;
  logic [31:0] section_count_q, section_count_d;
  logic [32:0] raw_sum_q, raw_sum_d;
  logic [31:0] packer_code_q, packer_code_d;
  logic [33:0] chunk_start_q, chunk_start_d;

  ccv_pkg::out_item_t res0, res1;
  logic [1:0] res_cnt;

  ccv_pkg::out_item_t q_mem [ccv_pkg::QDepth];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] count_q;

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign in_stall_o  = count_q > 3'(ccv_pkg::QDepth - 2);
  assign out_valid_o = count_q != 3'd0;
  assign out_data_o  = q_mem[rd_ptr_q];

  always_comb begin
    logic [7:0]  b;
    logic [33:0] consumed;
    logic [32:0] tp8;
    logic [3:0]  err;
    logic [3:0]  hl;
    logic [3:0]  w;
    logic [31:0] i;
    logic [32:0] sc_inc;
    logic        known;
    logic        emit_hdr, emit_chunk, do_adv, do_walk, do_fin;
    logic [3:0]  fin_st;
    logic [32:0] r4;
    logic [34:0] nxt;
    ccv_pkg::out_item_t chunk_res, fin_res;

    b        = in_data_i.data_byte;
    consumed = {1'b0, byte_offset_q} + 34'd1;
    tp8      = {1'b0, total_packed_q} + 33'd8;
    err      = ccv_pkg::StOk;
    emit_hdr = 1'b0; emit_chunk = 1'b0; do_adv = 1'b0; do_walk = 1'b0;
    do_fin   = 1'b0; fin_st = ccv_pkg::StOk;
    hl = header_flags_q[0] ? 4'd12 : 4'd8;
    w  = header_flags_q[0] ? 4'd4 : 4'd2;
    i  = section_count_q;
    sc_inc = {1'b0, section_count_q} + 33'd1;
    known = 1'b0;
    r4 = '0; nxt = '0;
    chunk_res = '0; fin_res = '0;
    res0 = '0; res1 = '0; res_cnt = 2'd0;

    phase_d = phase_q; byte_offset_d = byte_offset_q; field_shift_d = field_shift_q;
    total_packed_d = total_packed_q; total_raw_d = total_raw_q;
    header_flags_d = header_flags_q; header_length_d = header_length_q;
    header_xor_d = header_xor_q; lane_xor_d = lane_xor_q; check_value_d = check_value_q;
    current_type_d = current_type_q; current_packed_d = current_packed_q;
    current_raw_d = current_raw_q; section_count_d = section_count_q;
    raw_sum_d = raw_sum_q; packer_code_d = packer_code_q; chunk_start_d = chunk_start_q;

    byte_offset_d = consumed[33] ? '1 : consumed[32:0];

    unique case (phase_q)
      ccv_pkg::PH_HDR: begin
        if (byte_offset_q < 33'd36) header_xor_d = header_xor_q ^ b;
        if (byte_offset_q < 33'd16) field_shift_d = {field_shift_q[23:0], b};
        priority if (byte_offset_q == 33'd3 && field_shift_d != ccv_pkg::MagicXpkf) begin
          err = ccv_pkg::StMagic;
        end else if (byte_offset_q == 33'd7) begin
          total_packed_d = field_shift_d;
        end else if (byte_offset_q == 33'd11) begin
          packer_code_d = field_shift_d;
        end else if (byte_offset_q == 33'd15) begin
          total_raw_d = field_shift_d;
          if (field_shift_d == '0 || total_packed_q == '0 || field_shift_d > max_raw_q ||
              total_packed_q > max_packed_q) err = ccv_pkg::StSize;
        end else if (byte_offset_q == 33'd32) begin
          header_flags_d = b[2:0];
          if (b[1]) err = ccv_pkg::StPassword;
        end else if (byte_offset_q == 33'd35) begin
          if (verify_q && header_xor_d != 8'd0) err = ccv_pkg::StHdrSum;
        end else if (header_flags_q[2] && byte_offset_q == 33'd36) begin
          field_shift_d = {24'd0, b};
        end else if (header_flags_q[2] && byte_offset_q == 33'd37) begin
          field_shift_d = {16'd0, field_shift_q[7:0], b};
          header_length_d = 17'd38 + {1'b0, field_shift_q[7:0], b};
        end else begin
        end
        if (err != ccv_pkg::StOk) begin
          do_fin = 1'b1; fin_st = err;
        end else if (consumed >= 34'd36 && (!header_flags_d[2] ||
                     (consumed >= 34'd38 && consumed == {17'd0, header_length_d}))) begin
          emit_hdr = 1'b1;
          chunk_start_d = consumed;
          section_count_d = '0; header_xor_d = '0; current_type_d = '0;
          current_packed_d = '0; current_raw_d = '0; check_value_d = '0; lane_xor_d = '0;
          phase_d = ccv_pkg::PH_CHDR;
        end
      end
      ccv_pkg::PH_CHDR: begin
        header_xor_d = header_xor_q ^ b;
        if (i == 32'd0) current_type_d = b;
        else if (i == 32'd2 || i == 32'd3) check_value_d = {check_value_q[7:0], b};
        else if (i >= 32'd4 && i < 32'(4 + w)) current_packed_d = {current_packed_q[23:0], b};
        else if (i >= 32'(4 + w) && i < 32'(4 + 2 * w))
          current_raw_d = {current_raw_q[23:0], b};
        section_count_d = sc_inc[31:0];
        if (sc_inc == 33'(hl)) begin
          known = current_type_d == 8'd0 || current_type_d == 8'd1 || current_type_d == 8'd15;
          priority if (verify_q && header_xor_d != 8'd0) begin
            do_fin = 1'b1; fin_st = ccv_pkg::StChunkSum;
          end else if (verify_q && !known) begin
            do_fin = 1'b1; fin_st = ccv_pkg::StType;
          end else if (!known) begin
            emit_chunk = 1'b1; do_walk = 1'b1;
          end else if (current_type_d == 8'd0 && current_raw_d != '0 &&
                       current_raw_d != current_packed_d) begin
            do_fin = 1'b1; fin_st = ccv_pkg::StStored;
          end else if (raw_sum_q + {1'b0, current_raw_d} > {1'b0, total_raw_q}) begin
            do_fin = 1'b1; fin_st = ccv_pkg::StRawTotal;
          end else begin
            raw_sum_d = raw_sum_q + {1'b0, current_raw_d};
            if (current_packed_d == '0) begin
              emit_chunk = 1'b1; do_adv = 1'b1;
            end else begin
              section_count_d = '0; lane_xor_d = '0; phase_d = ccv_pkg::PH_DATA;
            end
          end
        end
      end
      ccv_pkg::PH_DATA: begin
        lane_xor_d = lane_xor_q ^ (section_count_q[0] ? {8'd0, b} : {b, 8'd0});
        section_count_d = sc_inc[31:0];
        if (sc_inc >= {1'b0, current_packed_q}) begin
          if (verify_q && lane_xor_d != check_value_q) begin
            do_fin = 1'b1; fin_st = ccv_pkg::StDataSum;
          end else begin
            emit_chunk = 1'b1; do_adv = 1'b1;
          end
        end
      end
      ccv_pkg::PH_PAD: begin
        if (section_count_q != '0) section_count_d = section_count_q - 32'd1;
        if (section_count_d == '0) begin
          chunk_start_d = consumed;
          section_count_d = '0; header_xor_d = '0; current_type_d = '0;
          current_packed_d = '0; current_raw_d = '0; check_value_d = '0; lane_xor_d = '0;
          phase_d = ccv_pkg::PH_CHDR;
        end
      end
      ccv_pkg::PH_TAIL: begin
        if (consumed >= {1'b0, tp8}) begin
          do_fin = 1'b1; fin_st = ccv_pkg::StOk;
        end
      end
      ccv_pkg::PH_DRAIN: begin
      end
      default: begin
      end
    endcase

    chunk_res = '{kind: ccv_pkg::KindChunk, status: ccv_pkg::StOk,
                  packer_type: packer_code_d, chunk_kind: current_type_d,
                  chunk_offset: chunk_start_d[31:0], chunk_packed_size: current_packed_d,
                  chunk_raw_size: current_raw_d, last: 1'b0};

    if (do_adv) begin
      r4  = ({1'b0, current_packed_d} + 33'd3) & ~33'd3;
      nxt = {1'b0, chunk_start_d} + 35'(hl) + {2'b0, r4};
      if (current_type_d == 8'd15 || nxt >= {2'b0, tp8}) begin
        do_walk = 1'b1;
      end else if (r4 != {1'b0, current_packed_d}) begin
        section_count_d = r4[31:0] - current_packed_d;
        phase_d = ccv_pkg::PH_PAD;
      end else begin
        chunk_start_d = consumed;
        section_count_d = '0; header_xor_d = '0; current_type_d = '0;
        current_packed_d = '0; current_raw_d = '0; check_value_d = '0; lane_xor_d = '0;
        phase_d = ccv_pkg::PH_CHDR;
      end
    end

    if (do_walk) begin
      if (raw_sum_d != {1'b0, total_raw_d}) begin
        do_fin = 1'b1; fin_st = ccv_pkg::StRawTotal;
      end else if (consumed >= {1'b0, tp8}) begin
        do_fin = 1'b1; fin_st = ccv_pkg::StOk;
      end else begin
        phase_d = ccv_pkg::PH_TAIL;
      end
    end

    if (!do_fin && in_data_i.end_of_file && phase_d != ccv_pkg::PH_DRAIN) begin
      do_fin = 1'b1; fin_st = ccv_pkg::StTruncated;
    end
    if (do_fin) phase_d = ccv_pkg::PH_DRAIN;

    fin_res = '{kind: ccv_pkg::KindEnd, status: fin_st,
                packer_type: packer_code_d, chunk_kind: current_type_d,
                chunk_offset: chunk_start_d[31:0], chunk_packed_size: current_packed_d,
                chunk_raw_size: current_raw_d, last: 1'b1};

    // transfer order: header or chunk result first, final status after
    if (emit_hdr) begin
      res0 = '{kind: ccv_pkg::KindHeader, status: ccv_pkg::StOk,
               packer_type: packer_code_d, default: '0};
      res_cnt = 2'd1;
    end else if (emit_chunk) begin
      res0 = chunk_res;
      res_cnt = 2'd1;
    end
    if (do_fin) begin
      if (res_cnt == 2'd0) res0 = fin_res;
      else res1 = fin_res;
      res_cnt = res_cnt + 2'd1;
    end

    if (in_data_i.end_of_file) begin
      phase_d = ccv_pkg::PH_HDR;
      byte_offset_d = '0; field_shift_d = '0; total_packed_d = '0; total_raw_d = '0;
      header_flags_d = '0; header_length_d = 17'd36; header_xor_d = '0; lane_xor_d = '0;
      check_value_d = '0; current_type_d = '0; current_packed_d = '0; current_raw_d = '0;
      section_count_d = '0; raw_sum_d = '0; packer_code_d = '0; chunk_start_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_raw_q    <= 32'hFFFF_FFFF;
      max_packed_q <= 32'hFFFF_FFF7;
      verify_q     <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ccv_pkg::CFG_MAX_RAW:    max_raw_q    <= cfg_data_i;
        ccv_pkg::CFG_MAX_PACKED: max_packed_q <= cfg_data_i;
        ccv_pkg::CFG_VERIFY:     verify_q     <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ccv_pkg::PH_HDR;
      byte_offset_q <= '0; field_shift_q <= '0; total_packed_q <= '0; total_raw_q <= '0;
      header_flags_q <= '0; header_length_q <= 17'd36; header_xor_q <= '0;
      lane_xor_q <= '0; check_value_q <= '0; current_type_q <= '0;
      current_packed_q <= '0; current_raw_q <= '0; section_count_q <= '0;
      raw_sum_q <= '0; packer_code_q <= '0; chunk_start_q <= '0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      byte_offset_q <= byte_offset_d; field_shift_q <= field_shift_d;
      total_packed_q <= total_packed_d; total_raw_q <= total_raw_d;
      header_flags_q <= header_flags_d; header_length_q <= header_length_d;
      header_xor_q <= header_xor_d; lane_xor_q <= lane_xor_d;
      check_value_q <= check_value_d; current_type_q <= current_type_d;
      current_packed_q <= current_packed_d; current_raw_q <= current_raw_d;
      section_count_q <= section_count_d; raw_sum_q <= raw_sum_d;
      packer_code_q <= packer_code_d; chunk_start_q <= chunk_start_d;
    end
  end

  // result queue
  always_ff @(posedge clk_i) begin
    if (in_acc && res_cnt != 2'd0) q_mem[wr_ptr_q] <= res0;
    if (in_acc && res_cnt == 2'd2) q_mem[wr_ptr_q + 2'd1] <= res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_acc) wr_ptr_q <= wr_ptr_q + res_cnt;
      if (out_acc) rd_ptr_q <= rd_ptr_q + 2'd1;
      count_q <= count_q + (in_acc ? {1'b0, res_cnt} : 3'd0) - {2'b0, out_acc};
    end
  end

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 3'(ccv_pkg::QDepth))
    else $error("result queue overflow");

  a_eof_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.end_of_file |=> phase_q == ccv_pkg::PH_HDR && byte_offset_q == '0)
    else $error("file state not cleared after end of file");

  a_last_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |-> out_data_o.kind == ccv_pkg::KindEnd)
    else $error("final result without end kind");

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Testbench for the chunked container verifier: directed and random files checked by a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb;

  localparam int unsigned StallLimit = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ccv_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ccv_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  chunked_container_verifier dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [31:0] lim_raw, lim_packed;
  logic        chk_on;
  ccv_pkg::phase_e ph;
  logic [32:0] offs;
  logic [31:0] shreg, tot_packed, tot_raw;
  logic [2:0]  hflags;
  logic [16:0] hlen;
  logic [7:0]  hxor, ctype;
  logic [15:0] lanes, cval;
  logic [31:0] cpacked, craw, scount, pcode;
  logic [32:0] rsum, cstart;

  ccv_pkg::out_item_t expected_q[$];
  int errors = 0;
  int idle_cnt = 0;

  function automatic int gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [33:0] end_mark();
    return {2'b0, tot_packed} + 34'd8;
  endfunction

  task automatic file_clear();
    ph = ccv_pkg::PH_HDR; offs = '0; shreg = '0; tot_packed = '0; tot_raw = '0;
    hflags = '0; hlen = 17'd36; hxor = '0; lanes = '0; cval = '0; ctype = '0;
    cpacked = '0; craw = '0; scount = '0; rsum = '0; pcode = '0; cstart = '0;
  endtask

  task automatic push(logic [1:0] k, logic [3:0] st, bit chunk, bit lst);
    ccv_pkg::out_item_t o;
    o = '0;
    o.kind = k; o.status = st; o.packer_type = pcode; o.last = lst;
    if (chunk) begin
      o.chunk_kind = ctype; o.chunk_offset = cstart[31:0];
      o.chunk_packed_size = cpacked; o.chunk_raw_size = craw;
    end
    expected_q.push_back(o);
  endtask

  task automatic close_file(logic [3:0] st);
    push(ccv_pkg::KindEnd, st, 1'b1, 1'b1);
    ph = ccv_pkg::PH_DRAIN;
  endtask

  task automatic open_chunk(logic [32:0] at);
    cstart = at; scount = '0; hxor = '0; ctype = '0; cpacked = '0; craw = '0;
    cval = '0; lanes = '0; ph = ccv_pkg::PH_CHDR;
  endtask

  task automatic end_walk(logic [33:0] used);
    if (rsum != {1'b0, tot_raw}) close_file(ccv_pkg::StRawTotal);
    else if (used >= end_mark()) close_file(ccv_pkg::StOk);
    else ph = ccv_pkg::PH_TAIL;
  endtask

  task automatic next_chunk(logic [33:0] used);
    logic [33:0] r4, nxt;
    if (ctype == 8'd15) begin
      end_walk(used);
      return;
    end
    r4 = ({2'b0, cpacked} + 34'd3) & ~34'd3;
    nxt = {1'b0, cstart} + (hflags[0] ? 34'd12 : 34'd8) + r4;
    if (nxt >= end_mark()) end_walk(used);
    else if (r4 != {2'b0, cpacked}) begin
      scount = 32'(r4 - {2'b0, cpacked});
      ph = ccv_pkg::PH_PAD;
    end else open_chunk(used[32:0]);
  endtask

  // Works out the results caused by one accepted byte.
  task automatic predict_byte(ccv_pkg::in_item_t it);
    logic [7:0] b;
    logic [32:0] pos;
    logic [33:0] used;
    logic [3:0] err;
    logic [31:0] i, w;
    bit known;
    b = it.data_byte; pos = offs; used = {1'b0, offs} + 34'd1; err = ccv_pkg::StOk;
    offs = (used > 34'h1_FFFF_FFFF) ? 33'h1_FFFF_FFFF : used[32:0];
    case (ph)
      ccv_pkg::PH_HDR: begin
        if (pos < 36) hxor ^= b;
        if (pos < 16) shreg = {shreg[23:0], b};
        if (pos == 3 && shreg != ccv_pkg::MagicXpkf) err = ccv_pkg::StMagic;
        else if (pos == 7) tot_packed = shreg;
        else if (pos == 11) pcode = shreg;
        else if (pos == 15) begin
          tot_raw = shreg;
          if (tot_raw == 0 || tot_packed == 0 || tot_raw > lim_raw || tot_packed > lim_packed)
            err = ccv_pkg::StSize;
        end else if (pos == 32) begin
          hflags = b[2:0];
          if (b[1]) err = ccv_pkg::StPassword;
        end else if (pos == 35) begin
          if (chk_on && hxor != 0) err = ccv_pkg::StHdrSum;
        end else if (hflags[2] && pos == 36) shreg = {24'b0, b};
        else if (hflags[2] && pos == 37) begin
          shreg = {16'b0, shreg[7:0], b};
          hlen = 17'd38 + shreg[16:0];
        end
        if (err != ccv_pkg::StOk) close_file(err);
        else if (used >= 36 && (!hflags[2] || (used >= 38 && used == {17'b0, hlen}))) begin
          push(ccv_pkg::KindHeader, ccv_pkg::StOk, 1'b0, 1'b0);
          open_chunk(used[32:0]);
        end
      end
      ccv_pkg::PH_CHDR: begin
        w = hflags[0] ? 4 : 2;
        i = scount;
        hxor ^= b;
        if (i == 0) ctype = b;
        else if (i == 2 || i == 3) cval = {cval[7:0], b};
        else if (i >= 4 && i < 4 + w) cpacked = {cpacked[23:0], b};
        else if (i >= 4 + w && i < 4 + 2 * w) craw = {craw[23:0], b};
        scount = i + 1;
        if (scount == (hflags[0] ? 12 : 8)) begin
          known = ctype == 0 || ctype == 1 || ctype == 15;
          if (chk_on && hxor != 0) close_file(ccv_pkg::StChunkSum);
          else if (chk_on && !known) close_file(ccv_pkg::StType);
          else if (!known) begin
            push(ccv_pkg::KindChunk, ccv_pkg::StOk, 1'b1, 1'b0);
            end_walk(used);
          end else if (ctype == 0 && craw != 0 && craw != cpacked) close_file(ccv_pkg::StStored);
          else if (rsum + craw > {1'b0, tot_raw}) close_file(ccv_pkg::StRawTotal);
          else begin
            rsum += craw;
            if (cpacked == 0) begin
              push(ccv_pkg::KindChunk, ccv_pkg::StOk, 1'b1, 1'b0);
              next_chunk(used);
            end else begin
              scount = '0; lanes = '0; ph = ccv_pkg::PH_DATA;
            end
          end
        end
      end
      ccv_pkg::PH_DATA: begin
        lanes ^= scount[0] ? {8'b0, b} : {b, 8'b0};
        scount++;
        if (scount >= cpacked) begin
          if (chk_on && lanes != cval) close_file(ccv_pkg::StDataSum);
          else begin
            push(ccv_pkg::KindChunk, ccv_pkg::StOk, 1'b1, 1'b0);
            next_chunk(used);
          end
        end
      end
      ccv_pkg::PH_PAD: begin
        if (scount > 0) scount--;
        if (scount == 0) open_chunk(used[32:0]);
      end
      ccv_pkg::PH_TAIL: if (used >= end_mark()) close_file(ccv_pkg::StOk);
      default: ;
    endcase
    if (it.end_of_file) begin
      if (ph != ccv_pkg::PH_DRAIN) close_file(ccv_pkg::StTruncated);
      file_clear();
    end
  endtask

  // byte stream of the current file under construction
  logic [7:0] fbytes[$];

  task automatic put32(logic [31:0] v);
    for (int k = 3; k >= 0; k--) fbytes.push_back(v[8*k +: 8]);
  endtask

  // Builds a file; corrupt picks a fault to inject (0 none).
  task automatic build_file(bit long_hdr, bit extra, int nchunks, int corrupt);
    logic [7:0] hdr[$];
    logic [7:0] x, c[$];
    logic [15:0] lv;
    int plen, pk[$], rw[$], typ[$], body, extra_len, tot, total_raw_v;
    fbytes.delete();
    extra_len = extra ? $urandom_range(0, 5) : 0;
    total_raw_v = 0; body = 0;
    for (int n = 0; n < nchunks; n++) begin
      typ.push_back($urandom_range(0, 1));
      plen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 9);
      pk.push_back(plen);
      rw.push_back(typ[n] == 0 ? plen : $urandom_range(0, 30));
      total_raw_v += rw[n];
      body += (long_hdr ? 12 : 8) + ((plen + 3) & ~3);
    end
    if (total_raw_v == 0) begin
      typ[0] = 1; rw[0] = 5; total_raw_v = 5;
    end
    tot = (extra ? 38 + extra_len : 36) + body + (long_hdr ? 12 : 8) - 8;
    put32(corrupt == 1 ? 32'h5850_4B47 : ccv_pkg::MagicXpkf);
    put32(corrupt == 3 ? 32'd0 : 32'(tot));
    put32(32'($urandom()));
    put32(32'(corrupt == 10 ? total_raw_v + 1 : total_raw_v));
    for (int k = 16; k < 32; k++) fbytes.push_back(8'($urandom()));
    fbytes.push_back({5'($urandom()), extra, corrupt == 4, long_hdr});
    fbytes.push_back(8'($urandom())); fbytes.push_back(8'($urandom()));
    x = 0;
    for (int k = 0; k < 35; k++) x ^= fbytes[k];
    fbytes.push_back(corrupt == 2 ? ~x : x);
    if (extra) begin
      fbytes.push_back(8'd0); fbytes.push_back(8'(extra_len));
      for (int k = 0; k < extra_len; k++) fbytes.push_back(8'($urandom()));
    end
    for (int n = 0; n <= nchunks; n++) begin
      int t;
      c.delete();
      t = (n == nchunks) ? 15 : typ[n];
      if (n == 0 && corrupt == 7) t = $urandom_range(2, 14);
      plen = (n == nchunks) ? 0 : pk[n];
      lv = 0;
      for (int k = 0; k < plen; k++) begin
        x = 8'($urandom());
        hdr.push_back(x);
        lv ^= k[0] ? {8'b0, x} : {x, 8'b0};
      end
      if (n == 0 && corrupt == 6 && plen > 0) lv = ~lv;
      c.push_back(8'(t)); c.push_back(8'd0); c.push_back(lv[15:8]); c.push_back(lv[7:0]);
      if (long_hdr) begin
        for (int k = 3; k >= 0; k--) c.push_back(8'(plen >> (8 * k)));
        for (int k = 3; k >= 0; k--)
          c.push_back(8'(((n == nchunks) ? 0 : rw[n] + (n == 0 && corrupt == 8)) >> (8 * k)));
      end else begin
        c.push_back(8'(plen >> 8)); c.push_back(8'(plen));
        c.push_back(8'(((n == nchunks) ? 0 : rw[n] + (n == 0 && corrupt == 8)) >> 8));
        c.push_back(8'((n == nchunks) ? 0 : rw[n] + (n == 0 && corrupt == 8)));
      end
      x = 0;
      foreach (c[k]) x ^= c[k];
      c[1] = (n == 0 && corrupt == 5) ? ~x : x;
      foreach (c[k]) fbytes.push_back(c[k]);
      foreach (hdr[k]) fbytes.push_back(hdr[k]);
      for (int k = plen; k < ((plen + 3) & ~3); k++) fbytes.push_back(8'($urandom()));
      hdr.delete();
    end
    if (corrupt == 9) fbytes = fbytes[0:fbytes.size() - 3];
    // header faults end the file early, so the chunks are not needed
    if (corrupt >= 1 && corrupt <= 4) fbytes = fbytes[0:35];
    // random trailing bytes after the nominal end
    repeat ($urandom_range(0, 3)) fbytes.push_back(8'($urandom()));
  endtask

  // valid only drops when a gap follows, so back to back bytes keep it high
  task automatic send_byte(logic [7:0] b, logic eof);
    int n;
    n = gap();
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_data <= '{data_byte: b, end_of_file: eof};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_byte('{data_byte: b, end_of_file: eof});
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_file();
    foreach (fbytes[k]) send_byte(fbytes[k], k == fbytes.size() - 1);
  endtask

  task automatic cfg_write(ccv_pkg::cfg_idx_e idx, logic [31:0] v);
    idle_input();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ccv_pkg::CFG_MAX_RAW:    lim_raw = v;
      ccv_pkg::CFG_MAX_PACKED: lim_packed = v;
      default:                 chk_on = v[0];
    endcase
  endtask

  // receiver: random stalls, compare against oldest expectation
  always @(posedge clk) begin
    ccv_pkg::out_item_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result kind=%0d status=%0d", out_data.kind, out_data.status);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (out_data.kind !== e.kind) begin
            $error("kind exp %0d got %0d", e.kind, out_data.kind); errors++;
          end
          if (out_data.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_data.status); errors++;
          end
          if (out_data.packer_type !== e.packer_type) begin
            $error("packer_type exp %h got %h", e.packer_type, out_data.packer_type); errors++;
          end
          if (out_data.chunk_kind !== e.chunk_kind) begin
            $error("chunk_kind exp %0d got %0d", e.chunk_kind, out_data.chunk_kind); errors++;
          end
          if (out_data.chunk_offset !== e.chunk_offset) begin
            $error("chunk_offset exp %0d got %0d", e.chunk_offset, out_data.chunk_offset);
            errors++;
          end
          if (out_data.chunk_packed_size !== e.chunk_packed_size) begin
            $error("chunk_packed_size exp %0d got %0d", e.chunk_packed_size,
                   out_data.chunk_packed_size);
            errors++;
          end
          if (out_data.chunk_raw_size !== e.chunk_raw_size) begin
            $error("chunk_raw_size exp %0d got %0d", e.chunk_raw_size, out_data.chunk_raw_size);
            errors++;
          end
          if (out_data.last !== e.last) begin
            $error("last exp %0d got %0d", e.last, out_data.last); errors++;
          end
        end
      end
      out_stall <= (gap() > 0);
    end
  end

  // watchdog on transfers in either direction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > StallLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  typedef struct {
    logic [7:0] b;
    logic       eof;
  } dir_row_t;

  initial begin
    dir_row_t rows[$];
    lim_raw = 32'hFFFF_FFFF; lim_packed = 32'hFFFF_FFF7; chk_on = 1'b1;
    file_clear();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: bad magic at once, a single stray end byte, a truncated header
    rows = '{'{8'hFF, 1'b0}, '{8'h00, 1'b0}, '{8'h00, 1'b0}, '{8'h00, 1'b1},
             '{8'h00, 1'b1},
             '{8'h58, 1'b0}, '{8'h50, 1'b0}, '{8'h4B, 1'b0}, '{8'h46, 1'b0},
             '{8'hFF, 1'b0}, '{8'hFF, 1'b0}, '{8'hFF, 1'b0}, '{8'hFF, 1'b1}};
    foreach (rows[k]) send_byte(rows[k].b, rows[k].eof);
    idle_input();
    while (expected_q.size() != 0) @(posedge clk);

    // every fault class once, both header widths
    for (int f = 1; f <= 10; f++) begin
      build_file(f[0], f == 4 || f == 9, 1, f);
      send_file();
    end

    cfg_write(ccv_pkg::CFG_MAX_RAW, 32'd1);
    build_file(1'b0, 1'b0, 1, 0);
    send_file();
    cfg_write(ccv_pkg::CFG_MAX_PACKED, 32'd1);
    cfg_write(ccv_pkg::CFG_MAX_RAW, 32'hFFFF_FFFF);
    build_file(1'b0, 1'b0, 1, 0);
    send_file();
    cfg_write(ccv_pkg::CFG_MAX_PACKED, 32'hFFFF_FFF7);

    // random: phases of settings, verify on and off, a few limit tweaks
    for (int p = 0; p < 4; p++) begin
      cfg_write(ccv_pkg::CFG_VERIFY, p[0] ? 32'd0 : 32'd1);
      cfg_write(ccv_pkg::CFG_MAX_RAW, p == 2 ? 32'd60 : 32'hFFFF_FFFF);
      cfg_write(ccv_pkg::CFG_MAX_PACKED, p == 3 ? 32'd120 : 32'hFFFF_FFF7);
      begin
        int f;
        f = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
        build_file(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   $urandom_range(1, 2), f);
        send_file();
      end
      // noise bytes
      repeat (6) send_byte(8'($urandom()), $urandom_range(0, 5) == 0);
      send_byte(8'($urandom()), 1'b1);
    end
    cfg_write(ccv_pkg::CFG_VERIFY, 32'd1);

    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire
